FILE: rtl/dcp_pkg.sv
// Shared widths, register indexes and reset values of the distance constraint projector.
`timescale 1ns / 1ps
package dcp_pkg;

    localparam int COORD_W    = 32;
    localparam int MASS_W     = 24;
    localparam int REST_W     = 31;
    localparam int STIFF_W    = 17;
    localparam int EPS_W      = 16;
    localparam int WSUM_W     = MASS_W + 1;
    localparam int RAD_W      = 2 * COORD_W + 2;
    localparam int ROOT_W     = COORD_W + 2;
    localparam int FRAC_W     = 30;
    localparam int DIV_Q_W    = FRAC_W + 1;
    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 6 * COORD_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = STIFF_W;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 1'd1;

    localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd1;

endpackage

FILE: rtl/distance_constraint_projector.sv
// Top level of the pipelined position-based-dynamics distance constraint projector.
`timescale 1ns / 1ps
// One distance constraint per transfer goes in, one corrected particle pair comes out, in
// order. The pipeline takes a new constraint in every cycle unless the output stalls. It has
// three front stages (difference and weights, squares, sum of squares), 34 square root
// stages (one root bit each), 31 divider stages (one quotient bit each, for both the weight
// ratios and the unit gradient), two multiply stages and the output register.
// While a result waits on m_axis_tready the whole pipeline holds, so s_axis_tready follows
// the output side. Positions, the rest length and the inverse masses travel in s_axis_tdata;
// the active flag travels in s_axis_tuser and the applied flag in m_axis_tuser. Write
// stiffness and epsilon only while the pipeline is empty.
module distance_constraint_projector
    import dcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ax, ay, az, bx, by_pos, bz (32 each), inv_mass_a, inv_mass_b (24 each),
    // rest_length (31), one zero pad bit
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // active
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_ax, new_ay, new_az, new_bx, new_by, new_bz (32 each)
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // applied
    output logic                  m_axis_tuser
);

    typedef struct packed {
        logic                         active;
        logic                         s_ok;
        logic [2:0][COORD_W-1:0]      pa;
        logic [2:0][COORD_W-1:0]      pb;
        logic [2:0]                   dneg;
        logic [2:0][COORD_W-1:0]      dm;
        logic [1:0][WSUM_W-1:0]       kw;
        logic [WSUM_W-1:0]            wsum;
        logic [REST_W-1:0]            rest;
    } side_t;

    typedef struct packed {
        logic                         apply;
        logic                         cneg;
        logic [2:0]                   dneg;
        logic [2:0][COORD_W-1:0]      pa;
        logic [2:0][COORD_W-1:0]      pb;
        logic [ROOT_W-1:0]            cmag;
    } post_t;

    localparam int M_W = ROOT_W + 1;
    localparam int T_W = M_W + 1;
    localparam int X_W = T_W + 2;

    // Saturate a wide signed sum to the coordinate range.
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [X_W-1:0] v);
        logic hi_ok;
        hi_ok = (v[X_W-1:COORD_W-1] == '0) || (v[X_W-1:COORD_W-1] == '1);
        if (hi_ok) begin
            return v[COORD_W-1:0];
        end else if (v[X_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // ---------------------------------------------------------------- configuration
    logic [STIFF_W-1:0] stiff_reg;
    logic [EPS_W-1:0]   eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= STIFF_RESET;
            eps_reg   <= EPS_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_STIFFNESS: stiff_reg <= cfg_wdata;
                REG_EPSILON:   eps_reg   <= cfg_wdata[EPS_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // Advance every stage together whenever the output register is free or drained.
    logic en;
    logic m_valid_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = m_valid_reg;

    // ---------------------------------------------------------------- stage 1
    logic [2:0][COORD_W-1:0] in_a, in_b;
    logic [2:0][COORD_W:0]   diff_w;
    logic [2:0][COORD_W-1:0] dm_w;
    logic [2:0]              dneg_w;
    logic [MASS_W-1:0]       w_a, w_b;
    logic [REST_W-1:0]       rest_w;
    logic [MASS_W+STIFF_W-1:0] wprod_a_w, wprod_b_w;
    logic [WSUM_W-1:0]       wsum_w;
    side_t                   side1_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_a[k]   = s_axis_tdata[k*COORD_W +: COORD_W];
            in_b[k]   = s_axis_tdata[(k+3)*COORD_W +: COORD_W];
            diff_w[k] = {in_a[k][COORD_W-1], in_a[k]} - {in_b[k][COORD_W-1], in_b[k]};
            dneg_w[k] = diff_w[k][COORD_W];
            dm_w[k]   = dneg_w[k] ? COORD_W'(-diff_w[k]) : diff_w[k][COORD_W-1:0];
        end
        w_a       = s_axis_tdata[6*COORD_W +: MASS_W];
        w_b       = s_axis_tdata[6*COORD_W+MASS_W +: MASS_W];
        rest_w    = s_axis_tdata[6*COORD_W+2*MASS_W +: REST_W];
        wprod_a_w = (MASS_W+STIFF_W)'(w_a) * (MASS_W+STIFF_W)'(stiff_reg);
        wprod_b_w = (MASS_W+STIFF_W)'(w_b) * (MASS_W+STIFF_W)'(stiff_reg);
        wsum_w    = WSUM_W'(w_a) + WSUM_W'(w_b);

        side1_next.active = s_axis_tuser;
        side1_next.s_ok   = (wsum_w != '0) && (wsum_w >= WSUM_W'(eps_reg));
        side1_next.pa     = in_a;
        side1_next.pb     = in_b;
        side1_next.dneg   = dneg_w;
        side1_next.dm     = dm_w;
        side1_next.kw[0]  = wprod_a_w[MASS_W+STIFF_W-1:16];
        side1_next.kw[1]  = wprod_b_w[MASS_W+STIFF_W-1:16];
        side1_next.wsum   = wsum_w;
        side1_next.rest   = rest_w;
    end

    side_t side1_reg, side2_reg, side3_reg;
    logic  v1_reg, v2_reg, v3_reg;
    logic [2:0][2*COORD_W-1:0] sq_reg;
    logic [RAD_W-1:0]          sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= (2*COORD_W)'(side1_reg.dm[k]) * (2*COORD_W)'(side1_reg.dm[k]);
            end
            sum_reg <= RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
        end
    end

    // ---------------------------------------------------------------- square root
    logic [ROOT_W-1:0] root_w;

    dcp_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root_w)
    );

    // Hold the constraint beside the root pipeline.
    side_t             side_dly_reg [ROOT_W];
    logic [ROOT_W-1:0] vq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_dly_reg[0] <= side3_reg;
            for (int j = 1; j < ROOT_W; j++) begin
                side_dly_reg[j] <= side_dly_reg[j-1];
            end
        end
    end

    side_t side_q;
    assign side_q = side_dly_reg[ROOT_W-1];

    // ---------------------------------------------------------------- error and dividers
    logic [ROOT_W:0] cdiff_w;
    post_t           post_next;

    always_comb begin
        cdiff_w          = {1'b0, root_w} - (ROOT_W+1)'(side_q.rest);
        post_next.cneg   = cdiff_w[ROOT_W];
        post_next.cmag   = cdiff_w[ROOT_W] ? ROOT_W'(-cdiff_w) : cdiff_w[ROOT_W-1:0];
        post_next.apply  = side_q.active && side_q.s_ok && (root_w != '0);
        post_next.dneg   = side_q.dneg;
        post_next.pa     = side_q.pa;
        post_next.pb     = side_q.pb;
    end

    // r = (k << 30) / s for each particle, u = (|d| << 30) / L for each axis
    logic [1:0][DIV_Q_W-1:0] r_w;
    logic [2:0][DIV_Q_W-1:0] u_w;

    genvar gi;
    generate
        for (gi = 0; gi < 2; gi++) begin : g_rdiv
            dcp_div #(
                .NUM_W (WSUM_W + FRAC_W),
                .DEN_W (WSUM_W),
                .Q_W   (DIV_Q_W)
            ) u_div (
                .aclk (aclk),
                .en   (en),
                .num  ({side_q.kw[gi], {FRAC_W{1'b0}}}),
                .den  (side_q.wsum),
                .quo  (r_w[gi])
            );
        end
        for (gi = 0; gi < 3; gi++) begin : g_udiv
            dcp_div #(
                .NUM_W (COORD_W + FRAC_W),
                .DEN_W (ROOT_W),
                .Q_W   (DIV_Q_W)
            ) u_div (
                .aclk (aclk),
                .en   (en),
                .num  ({side_q.dm[gi], {FRAC_W{1'b0}}}),
                .den  (root_w),
                .quo  (u_w[gi])
            );
        end
    endgenerate

    post_t              post_dly_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0] vd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            post_dly_reg[0] <= post_next;
            for (int j = 1; j < DIV_Q_W; j++) begin
                post_dly_reg[j] <= post_dly_reg[j-1];
            end
        end
    end

    post_t post_q;
    assign post_q = post_dly_reg[DIV_Q_W-1];

    // ---------------------------------------------------------------- multiplies
    logic [1:0][ROOT_W+DIV_Q_W-1:0] mprod_w;
    logic [1:0][M_W-1:0]            m_reg;
    logic [2:0][DIV_Q_W-1:0]        u_reg;
    post_t                          post_m1_reg, post_m2_reg;
    logic                           vm1_reg, vm2_reg;
    logic [1:0][2:0][M_W+DIV_Q_W-1:0] tprod_w;
    logic [1:0][2:0][T_W-1:0]       t_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mprod_w[i] = (ROOT_W+DIV_Q_W)'(post_q.cmag) * (ROOT_W+DIV_Q_W)'(r_w[i]);
            for (int k = 0; k < 3; k++) begin
                tprod_w[i][k] = (M_W+DIV_Q_W)'(m_reg[i]) * (M_W+DIV_Q_W)'(u_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            post_m1_reg <= post_q;
            post_m2_reg <= post_m1_reg;
            u_reg       <= u_w;
            for (int i = 0; i < 2; i++) begin
                m_reg[i] <= mprod_w[i][ROOT_W+DIV_Q_W-1:FRAC_W];
                for (int k = 0; k < 3; k++) begin
                    t_reg[i][k] <= tprod_w[i][k][M_W+DIV_Q_W-1:FRAC_W];
                end
            end
        end
    end

    // ---------------------------------------------------------------- apply and saturate
    logic [OUT_DATA_W-1:0]      out_data_next, out_data_reg;
    logic                       applied_reg;
    logic signed [X_W-1:0]      tv_w [2][3];
    logic signed [X_W-1:0]      px_w [2][3];
    logic signed [X_W-1:0]      nx_w [2][3];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) begin
                px_w[i][k] = (i == 0) ? X_W'(signed'(post_m2_reg.pa[k]))
                                      : X_W'(signed'(post_m2_reg.pb[k]));
                // move against the gradient for the first particle, along it for the second
                tv_w[i][k] = (post_m2_reg.cneg ^ post_m2_reg.dneg[k]) ?
                             -signed'(X_W'(t_reg[i][k])) : signed'(X_W'(t_reg[i][k]));
                nx_w[i][k] = (i == 0) ? px_w[i][k] - tv_w[i][k] : px_w[i][k] + tv_w[i][k];
                out_data_next[(3*i+k)*COORD_W +: COORD_W] =
                    post_m2_reg.apply ? sat_coord(nx_w[i][k]) : px_w[i][k][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
            applied_reg  <= post_m2_reg.apply;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = applied_reg;

    // ---------------------------------------------------------------- valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            vq_reg      <= '0;
            vd_reg      <= '0;
            vm1_reg     <= 1'b0;
            vm2_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_axis_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            vq_reg      <= {vq_reg[ROOT_W-2:0], v3_reg};
            vd_reg      <= {vd_reg[DIV_Q_W-2:0], vq_reg[ROOT_W-1]};
            vm1_reg     <= vd_reg[DIV_Q_W-1];
            vm2_reg     <= vm1_reg;
            m_valid_reg <= vm2_reg;
        end
    end

endmodule

FILE: rtl/dcp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module dcp_sqrt
    import dcp_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    localparam int TW = RAD_W + 2;

    logic [TW-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_stage
            localparam int B = ROOT_W - 1 - g;
            logic [TW-1:0]     rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [TW-1:0]     trial;

            if (g == 0) begin : g_head
                assign rem_in  = TW'(radicand);
                assign root_in = '0;
            end else begin : g_body
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
            end

            // trial = (root << (b+1)) + 4^b keeps rem = N - root^2
            assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (rem_in >= trial) begin
                        rem_reg[g]  <= rem_in - trial;
                        root_reg[g] <= root_in | (ROOT_W'(1) << B);
                    end else begin
                        rem_reg[g]  <= rem_in;
                        root_reg[g] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

FILE: rtl/dcp_div.sv
// Pipelined restoring divider, one quotient bit per stage; quotient must fit Q_W bits.
`timescale 1ns / 1ps
module dcp_div #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 25,
    parameter int Q_W   = 31
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [RW-1:0]    rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            localparam int J = Q_W - 1 - g;
            logic [RW-1:0]    rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   quo_in;
            logic [RW-1:0]    shifted;

            if (g == 0) begin : g_head
                assign rem_in = RW'(num);
                assign den_in = den;
                assign quo_in = '0;
            end else begin : g_body
                assign rem_in = rem_reg[g-1];
                assign den_in = den_reg[g-1];
                assign quo_in = quo_reg[g-1];
            end

            assign shifted = RW'(den_in) << J;

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[g] <= den_in;
                    if (rem_in >= shifted) begin
                        rem_reg[g] <= rem_in - shifted;
                        quo_reg[g] <= quo_in | (Q_W'(1) << J);
                    end else begin
                        rem_reg[g] <= rem_in;
                        quo_reg[g] <= quo_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[Q_W-1];

endmodule
